FILE: rtl/core/dlpe_pkg.sv
// ----------------------------------------------------------------------------
// dlpe_pkg
// Shared types and link codes for the diagnostic link protocol engine.
// ----------------------------------------------------------------------------
package dlpe_pkg;

   localparam logic [1:0] KIND_FRAME    = 2'd0;
   localparam logic [1:0] KIND_RX_ERROR = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;
   localparam logic [1:0] KIND_WRITE    = 2'd3;

   localparam logic [1:0] WIDTH_BYTE    = 2'd1;

   localparam logic [8:0] CMD_MARK      = 9'h100;

   localparam logic [7:0] MODE_FLOOR    = 8'hD0;
   localparam logic [7:0] M_IDLE        = 8'hDA;
   localparam logic [7:0] M_RD_LSB      = 8'hD0;
   localparam logic [7:0] M_RD_RES      = 8'hD8;
   localparam logic [7:0] M_W16_MSB     = 8'hDD;
   localparam logic [7:0] M_W16_LSB     = 8'hD3;
   localparam logic [7:0] M_W16_DATA    = 8'hDE;
   localparam logic [7:0] M_W16_DLSB    = 8'hD4;
   localparam logic [7:0] M_W16_ACK     = 8'hDF;
   localparam logic [7:0] M_W8_MSB      = 8'hDC;
   localparam logic [7:0] M_W8_LSB      = 8'hD5;
   localparam logic [7:0] M_W8_DATA     = 8'hD6;
   localparam logic [7:0] M_W8_ACK      = 8'hD7;

   typedef struct packed {
      logic        tx_valid;
      logic [8:0]  tx_frame;
      logic        read_valid;
      logic [15:0] read_data;
      logic [1:0]  read_bytes;
      logic        read_last;
      logic        write_done;
      logic        resync;
      logic        stray;
      logic        busy_res;
   } rsp_type;

endpackage

FILE: rtl/core/diag_link_protocol_engine.sv
// ----------------------------------------------------------------------------
// diag_link_protocol_engine
// Slave side of a 9-bit marked memory-access link: decodes announcements and
// payload beats, tracks one read and one write, and picks at most one reply.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  kind, frame, address,
//                                             byte_count, write_width,
//                                             write_value
//   rsp_      out        rsp_valid/rsp_stall  tx_*, read_*, write_done,
//                                             resync, stray, busy_res
//
// One beat per cycle sustained while rsp_stall is low; each beat yields
// exactly one result beat via the input register, then the result register.
// Link state updates as a beat moves from the input register to the result
// register. Synchronous reset clears all state and empties both registers.
// A stalled result holds the input register; req_stall rises only then.
// ----------------------------------------------------------------------------
module diag_link_protocol_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_frame,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_byte_count,
   input  logic [1:0]  req_write_width,
   input  logic [15:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [8:0]  rsp_tx_frame,
   output logic        rsp_read_valid,
   output logic [15:0] rsp_read_data,
   output logic [1:0]  rsp_read_bytes,
   output logic        rsp_read_last,
   output logic        rsp_write_done,
   output logic        rsp_resync,
   output logic        rsp_stray,
   output logic        rsp_busy_res
);

   logic        in_valid_ff;
   logic [1:0]  kind_ff;
   logic [8:0]  frame_ff;
   logic [15:0] address_ff;
   logic [7:0]  byte_count_ff;
   logic [1:0]  write_width_ff;
   logic [15:0] write_value_ff;

   logic              out_valid_ff;
   dlpe_pkg::rsp_type out_ff, out_in;

   logic [7:0]  link_mode_ff, link_mode_in;
   logic [1:0]  payload_remaining_ff, payload_remaining_in;
   logic [1:0]  payload_position_ff, payload_position_in;
   logic [7:0]  payload_byte0_ff, payload_byte0_in;
   logic [7:0]  payload_byte1_ff, payload_byte1_in;
   logic        read_pending_ff, read_pending_in;
   logic [15:0] read_pointer_ff, read_pointer_in;
   logic [7:0]  read_left_ff, read_left_in;
   logic [15:0] write_pointer_ff, write_pointer_in;
   logic [15:0] write_word_ff, write_word_in;
   logic        write_is_byte_ff, write_is_byte_in;
   logic        write_addr_pending_ff, write_addr_pending_in;
   logic        write_data_pending_ff, write_data_pending_in;

   logic        out_free;
   logic        advance;
   logic        req_take;
   logic        group_done;
   logic [7:0]  group_mode;
   logic [1:0]  chunk_bytes;
   logic [15:0] readback;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff        <= req_kind;
         frame_ff       <= req_frame;
         address_ff     <= req_address;
         byte_count_ff  <= req_byte_count;
         write_width_ff <= req_write_width;
         write_value_ff <= req_write_value;
      end
   end

   always_comb begin
      link_mode_in          = link_mode_ff;
      payload_remaining_in  = payload_remaining_ff;
      payload_position_in   = payload_position_ff;
      payload_byte0_in      = payload_byte0_ff;
      payload_byte1_in      = payload_byte1_ff;
      read_pending_in       = read_pending_ff;
      read_pointer_in       = read_pointer_ff;
      read_left_in          = read_left_ff;
      write_pointer_in      = write_pointer_ff;
      write_word_in         = write_word_ff;
      write_is_byte_in      = write_is_byte_ff;
      write_addr_pending_in = write_addr_pending_ff;
      write_data_pending_in = write_data_pending_ff;
      out_in                = '0;
      group_done            = 1'b0;
      group_mode            = link_mode_ff;
      chunk_bytes           = '0;
      readback              = '0;

      case (kind_ff)
         dlpe_pkg::KIND_FRAME: begin
            if (frame_ff[8]) begin
               if (frame_ff[7:0] >= dlpe_pkg::MODE_FLOOR) begin
                  link_mode_in        = frame_ff[7:0];
                  group_mode          = frame_ff[7:0];
                  payload_position_in = 2'd0;
                  if (frame_ff[7:0] == dlpe_pkg::M_RD_RES ||
                      frame_ff[7:0] == dlpe_pkg::M_W16_ACK) begin
                     payload_remaining_in = 2'd2;
                  end else if (frame_ff[7:0] == dlpe_pkg::M_W8_ACK) begin
                     payload_remaining_in = 2'd1;
                  end else begin
                     payload_remaining_in = 2'd0;
                     group_done           = 1'b1;
                  end
               end
            end else if (payload_remaining_ff != 2'd0) begin
               if (payload_position_ff == 2'd0) begin
                  payload_byte0_in    = frame_ff[7:0];
                  payload_position_in = 2'd1;
               end else if (payload_position_ff == 2'd1) begin
                  payload_byte1_in    = frame_ff[7:0];
                  payload_position_in = 2'd2;
               end
               payload_remaining_in = payload_remaining_ff - 2'd1;
               group_done           = (payload_remaining_ff == 2'd1);
            end else begin
               out_in.stray = 1'b1;
            end
         end
         dlpe_pkg::KIND_RX_ERROR: begin
            payload_remaining_in = 2'd0;
            out_in.resync        = 1'b1;
         end
         dlpe_pkg::KIND_READ: begin
            if (read_pending_ff) begin
               out_in.busy_res = 1'b1;
            end else begin
               read_pointer_in = address_ff;
               read_left_in    = byte_count_ff;
               read_pending_in = 1'b1;
            end
         end
         default: begin
            if (write_addr_pending_ff || write_data_pending_ff) begin
               out_in.busy_res = 1'b1;
            end else begin
               write_pointer_in      = address_ff;
               write_is_byte_in      = (write_width_ff == dlpe_pkg::WIDTH_BYTE);
               write_word_in         = (write_width_ff == dlpe_pkg::WIDTH_BYTE)
                                     ? {8'h00, write_value_ff[7:0]} : write_value_ff;
               write_addr_pending_in = 1'b1;
            end
         end
      endcase

      if (group_done) begin
         unique case (group_mode) inside
            dlpe_pkg::M_IDLE: begin
               if (read_pending_ff) begin
                  out_in.tx_valid = 1'b1;
                  out_in.tx_frame = {1'b0, read_pointer_ff[15:8]};
               end else if (write_addr_pending_ff || write_data_pending_ff) begin
                  out_in.tx_valid = 1'b1;
                  out_in.tx_frame = dlpe_pkg::CMD_MARK | {1'b0, (write_is_byte_ff
                                  ? dlpe_pkg::M_W8_MSB : dlpe_pkg::M_W16_MSB)};
               end
            end
            dlpe_pkg::M_RD_LSB: begin
               out_in.tx_valid = 1'b1;
               out_in.tx_frame = {1'b0, read_pointer_ff[7:0]};
            end
            dlpe_pkg::M_RD_RES: begin
               if (read_pending_ff) begin
                  chunk_bytes = (read_left_ff > 8'd2) ? 2'd2 : read_left_ff[1:0];
                  out_in.read_valid = 1'b1;
                  out_in.read_bytes = chunk_bytes;
                  out_in.read_data  = {(chunk_bytes != 2'd0) ? payload_byte0_in : 8'h00,
                                       (chunk_bytes == 2'd2) ? payload_byte1_in : 8'h00};
                  read_left_in      = read_left_ff - {6'd0, chunk_bytes};
                  read_pointer_in   = read_pointer_ff + {14'd0, chunk_bytes};
                  if (read_left_ff == {6'd0, chunk_bytes}) begin
                     read_pending_in  = 1'b0;
                     out_in.read_last = 1'b1;
                  end
               end else begin
                  out_in.stray = 1'b1;
               end
               out_in.tx_valid = 1'b1;
               out_in.tx_frame = dlpe_pkg::CMD_MARK | {1'b0, dlpe_pkg::M_IDLE};
            end
            dlpe_pkg::M_W16_MSB, dlpe_pkg::M_W8_MSB: begin
               out_in.tx_valid = 1'b1;
               out_in.tx_frame = {1'b0, write_pointer_ff[15:8]};
            end
            dlpe_pkg::M_W16_LSB, dlpe_pkg::M_W8_LSB: begin
               out_in.tx_valid = 1'b1;
               out_in.tx_frame = {1'b0, write_pointer_ff[7:0]};
            end
            dlpe_pkg::M_W16_DATA, dlpe_pkg::M_W8_DATA: begin
               if (write_addr_pending_ff) begin
                  write_addr_pending_in = 1'b0;
                  write_data_pending_in = 1'b1;
               end else if (!write_data_pending_ff) begin
                  out_in.tx_valid = 1'b1;
                  out_in.tx_frame = dlpe_pkg::CMD_MARK | {1'b0, dlpe_pkg::M_IDLE};
               end else begin
                  out_in.tx_valid = 1'b1;
                  out_in.tx_frame = {1'b0, (group_mode == dlpe_pkg::M_W8_DATA)
                                  ? write_word_ff[7:0] : write_word_ff[15:8]};
               end
            end
            dlpe_pkg::M_W16_DLSB: begin
               out_in.tx_valid = 1'b1;
               out_in.tx_frame = write_data_pending_ff
                               ? {1'b0, write_word_ff[7:0]}
                               : dlpe_pkg::CMD_MARK | {1'b0, dlpe_pkg::M_IDLE};
            end
            dlpe_pkg::M_W16_ACK, dlpe_pkg::M_W8_ACK: begin
               readback = (group_mode == dlpe_pkg::M_W8_ACK)
                        ? {8'h00, payload_byte0_in}
                        : {payload_byte0_in, payload_byte1_in};
               if (readback == write_word_ff) begin
                  write_data_pending_in = 1'b0;
                  out_in.write_done     = 1'b1;
               end
            end
            default: begin
               out_in.resync = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_mode_ff          <= '0;
         payload_remaining_ff  <= '0;
         payload_position_ff   <= '0;
         payload_byte0_ff      <= '0;
         payload_byte1_ff      <= '0;
         read_pending_ff       <= 1'b0;
         read_pointer_ff       <= '0;
         read_left_ff          <= '0;
         write_pointer_ff      <= '0;
         write_word_ff         <= '0;
         write_is_byte_ff      <= 1'b0;
         write_addr_pending_ff <= 1'b0;
         write_data_pending_ff <= 1'b0;
      end else if (advance) begin
         link_mode_ff          <= link_mode_in;
         payload_remaining_ff  <= payload_remaining_in;
         payload_position_ff   <= payload_position_in;
         payload_byte0_ff      <= payload_byte0_in;
         payload_byte1_ff      <= payload_byte1_in;
         read_pending_ff       <= read_pending_in;
         read_pointer_ff       <= read_pointer_in;
         read_left_ff          <= read_left_in;
         write_pointer_ff      <= write_pointer_in;
         write_word_ff         <= write_word_in;
         write_is_byte_ff      <= write_is_byte_in;
         write_addr_pending_ff <= write_addr_pending_in;
         write_data_pending_ff <= write_data_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_tx_valid   = out_ff.tx_valid;
   assign rsp_tx_frame   = out_ff.tx_frame;
   assign rsp_read_valid = out_ff.read_valid;
   assign rsp_read_data  = out_ff.read_data;
   assign rsp_read_bytes = out_ff.read_bytes;
   assign rsp_read_last  = out_ff.read_last;
   assign rsp_write_done = out_ff.write_done;
   assign rsp_resync     = out_ff.resync;
   assign rsp_stray      = out_ff.stray;
   assign rsp_busy_res   = out_ff.busy_res;

endmodule

FILE: tb/sv/tb_diag_link_protocol_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_diag_link_protocol_engine
// Self-checking bench for the link protocol engine. A short table of directed
// beats (some with hand-written replies) is followed by random read, write
// and noise sequences under four flow-control phases. Every reply beat is
// compared against its hand-written reply or a cycle-free link-state model.
// ----------------------------------------------------------------------------
module tb_diag_link_protocol_engine;

   typedef struct packed {
      logic [1:0]  kind;
      logic [8:0]  frame;
      logic [15:0] address;
      logic [7:0]  byte_count;
      logic [1:0]  write_width;
      logic [15:0] write_value;
   } link_beat_type;

   typedef struct packed {
      link_beat_type     beat;
      bit                typed;
      dlpe_pkg::rsp_type want;
   } step_row_type;

   localparam int                CYCLE_LIMIT     = 200000;
   localparam int                BEATS_PER_PHASE = 240;
   localparam dlpe_pkg::rsp_type NO_RSP          = '0;
   localparam logic [3:0] F_WDONE  = 4'b1000;
   localparam logic [3:0] F_RESYNC = 4'b0100;
   localparam logic [3:0] F_STRAY  = 4'b0010;
   localparam logic [3:0] F_BUSY   = 4'b0001;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [8:0]  req_frame = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_byte_count = '0;
   logic [1:0]  req_write_width = '0;
   logic [15:0] req_write_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_tx_valid;
   logic [8:0]  rsp_tx_frame;
   logic        rsp_read_valid;
   logic [15:0] rsp_read_data;
   logic [1:0]  rsp_read_bytes;
   logic        rsp_read_last;
   logic        rsp_write_done;
   logic        rsp_resync;
   logic        rsp_stray;
   logic        rsp_busy_res;

   // link model state
   logic [7:0]  lk_mode = '0;
   logic [1:0]  pl_left = '0;
   logic [1:0]  pl_pos = '0;
   logic [7:0]  pl_byte [2] = '{8'h00, 8'h00};
   logic        rd_pend = 1'b0;
   logic [15:0] rd_addr = '0;
   logic [7:0]  rd_count = '0;
   logic [15:0] wr_addr = '0;
   logic [15:0] wr_word = '0;
   logic        wr_byte = 1'b0;
   logic        wr_addr_pend = 1'b0;
   logic        wr_data_pend = 1'b0;

   dlpe_pkg::rsp_type reply_q [$];
   link_beat_type     plan_q [$];
   step_row_type      dir_rows [$];
   int                bad_replies = 0;
   int                idle_pct = 0;
   int                stall_pct = 0;

   diag_link_protocol_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_frame       (req_frame),
      .req_address     (req_address),
      .req_byte_count  (req_byte_count),
      .req_write_width (req_write_width),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_frame    (rsp_tx_frame),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_read_bytes  (rsp_read_bytes),
      .rsp_read_last   (rsp_read_last),
      .rsp_write_done  (rsp_write_done),
      .rsp_resync      (rsp_resync),
      .rsp_stray       (rsp_stray),
      .rsp_busy_res    (rsp_busy_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void tx_data(inout dlpe_pkg::rsp_type r, input logic [7:0] d);
      r.tx_valid = 1'b1;
      r.tx_frame = {1'b0, d};
   endfunction

   function automatic void tx_cmd(inout dlpe_pkg::rsp_type r, input logic [7:0] m);
      r.tx_valid = 1'b1;
      r.tx_frame = dlpe_pkg::CMD_MARK | {1'b0, m};
   endfunction

   function automatic void close_group(inout dlpe_pkg::rsp_type r);
      logic [7:0]  take;
      logic [15:0] back;
      case (lk_mode)
         dlpe_pkg::M_IDLE: begin
            if (rd_pend) tx_data(r, rd_addr[15:8]);
            else if (wr_addr_pend || wr_data_pend)
               tx_cmd(r, wr_byte ? dlpe_pkg::M_W8_MSB : dlpe_pkg::M_W16_MSB);
         end
         dlpe_pkg::M_RD_LSB: tx_data(r, rd_addr[7:0]);
         dlpe_pkg::M_RD_RES: begin
            if (rd_pend) begin
               take = (rd_count > 8'd2) ? 8'd2 : rd_count;
               r.read_valid = 1'b1;
               r.read_data  = {(take > 8'd0) ? pl_byte[0] : 8'h00,
                               (take > 8'd1) ? pl_byte[1] : 8'h00};
               r.read_bytes = take[1:0];
               rd_count = rd_count - take;
               rd_addr = rd_addr + {8'h00, take};
               if (rd_count == 8'd0) begin
                  rd_pend = 1'b0;
                  r.read_last = 1'b1;
               end
            end else r.stray = 1'b1;
            tx_cmd(r, dlpe_pkg::M_IDLE);
         end
         dlpe_pkg::M_W16_MSB, dlpe_pkg::M_W8_MSB: tx_data(r, wr_addr[15:8]);
         dlpe_pkg::M_W16_LSB, dlpe_pkg::M_W8_LSB: tx_data(r, wr_addr[7:0]);
         dlpe_pkg::M_W16_DATA, dlpe_pkg::M_W8_DATA: begin
            if (wr_addr_pend) begin
               wr_addr_pend = 1'b0;
               wr_data_pend = 1'b1;
            end else if (!wr_data_pend) tx_cmd(r, dlpe_pkg::M_IDLE);
            else if (lk_mode == dlpe_pkg::M_W8_DATA) tx_data(r, wr_word[7:0]);
            else tx_data(r, wr_word[15:8]);
         end
         dlpe_pkg::M_W16_DLSB: begin
            if (wr_data_pend) tx_data(r, wr_word[7:0]);
            else tx_cmd(r, dlpe_pkg::M_IDLE);
         end
         dlpe_pkg::M_W16_ACK, dlpe_pkg::M_W8_ACK: begin
            back = (lk_mode == dlpe_pkg::M_W8_ACK) ? {8'h00, pl_byte[0]}
                                                   : {pl_byte[0], pl_byte[1]};
            if (back == wr_word) begin
               wr_data_pend = 1'b0;
               r.write_done = 1'b1;
            end
         end
         default: r.resync = 1'b1;
      endcase
   endfunction

   function automatic dlpe_pkg::rsp_type link_reply(link_beat_type b);
      dlpe_pkg::rsp_type r;
      r = '0;
      case (b.kind)
         dlpe_pkg::KIND_FRAME: begin
            if (b.frame[8]) begin
               if (b.frame[7:0] >= dlpe_pkg::MODE_FLOOR) begin
                  lk_mode = b.frame[7:0];
                  pl_pos = 2'd0;
                  if (lk_mode == dlpe_pkg::M_RD_RES || lk_mode == dlpe_pkg::M_W16_ACK)
                     pl_left = 2'd2;
                  else if (lk_mode == dlpe_pkg::M_W8_ACK) pl_left = 2'd1;
                  else pl_left = 2'd0;
                  if (pl_left == 2'd0) close_group(r);
               end
            end else if (pl_left != 2'd0) begin
               if (pl_pos < 2'd2) begin
                  pl_byte[pl_pos[0]] = b.frame[7:0];
                  pl_pos = pl_pos + 2'd1;
               end
               pl_left = pl_left - 2'd1;
               if (pl_left == 2'd0) close_group(r);
            end else r.stray = 1'b1;
         end
         dlpe_pkg::KIND_RX_ERROR: begin
            pl_left = 2'd0;
            r.resync = 1'b1;
         end
         dlpe_pkg::KIND_READ: begin
            if (rd_pend) r.busy_res = 1'b1;
            else begin
               rd_addr = b.address;
               rd_count = b.byte_count;
               rd_pend = 1'b1;
            end
         end
         default: begin
            if (wr_addr_pend || wr_data_pend) r.busy_res = 1'b1;
            else begin
               wr_addr = b.address;
               wr_byte = (b.write_width == dlpe_pkg::WIDTH_BYTE);
               wr_word = wr_byte ? {8'h00, b.write_value[7:0]} : b.write_value;
               wr_addr_pend = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   function automatic dlpe_pkg::rsp_type fixed_rsp(logic txv, logic [8:0] txf, logic rdv,
                                                   logic [15:0] rdd, logic [1:0] rdb,
                                                   logic rdl, logic [3:0] flags);
      return {txv, txf, rdv, rdd, rdb, rdl, flags};
   endfunction

   function automatic link_beat_type mk_beat(logic [1:0] k, logic [8:0] f, logic [15:0] a,
                                             logic [7:0] n, logic [1:0] w,
                                             logic [15:0] v);
      return {k, f, a, n, w, v};
   endfunction

   function automatic void add_row(link_beat_type b, bit typed, dlpe_pkg::rsp_type want);
      dir_rows.push_back({b, typed, want});
   endfunction

   function automatic link_beat_type rnd_beat(logic [1:0] k);
      return mk_beat(k, 9'($urandom), 16'($urandom), 8'($urandom), 2'($urandom),
                     16'($urandom));
   endfunction

   function automatic void plan_frame(logic [8:0] f);
      link_beat_type b;
      b = rnd_beat(dlpe_pkg::KIND_FRAME);
      b.frame = f;
      plan_q.push_back(b);
   endfunction

   function automatic void plan_read();
      link_beat_type b;
      int left;
      int chunks;
      if (!rd_pend) begin
         b = rnd_beat(dlpe_pkg::KIND_READ);
         if ($urandom_range(19) != 0) b.byte_count = 8'($urandom_range(7));
         plan_q.push_back(b);
         left = b.byte_count;
      end else left = rd_count;
      if ($urandom_range(1) != 0) plan_frame({1'b1, dlpe_pkg::M_IDLE});
      if ($urandom_range(3) != 0) plan_frame({1'b1, dlpe_pkg::M_RD_LSB});
      if ($urandom_range(9) == 0) plan_q.push_back(rnd_beat(dlpe_pkg::KIND_READ));
      chunks = (left + 1) / 2;
      if (chunks == 0) chunks = 1;
      if (chunks > 6) chunks = 6;
      for (int i = 0; i < chunks; i++) begin
         plan_frame({1'b1, dlpe_pkg::M_RD_RES});
         plan_frame({1'b0, 8'($urandom)});
         plan_frame({1'b0, 8'($urandom)});
      end
   endfunction

   function automatic void plan_write();
      link_beat_type b;
      logic          byte_w;
      logic [15:0]   word;
      if (!wr_addr_pend && !wr_data_pend) begin
         b = rnd_beat(dlpe_pkg::KIND_WRITE);
         if ($urandom_range(3) != 0) b.write_width = 2'($urandom_range(1, 2));
         plan_q.push_back(b);
         byte_w = (b.write_width == dlpe_pkg::WIDTH_BYTE);
         word = byte_w ? {8'h00, b.write_value[7:0]} : b.write_value;
      end else begin
         byte_w = wr_byte;
         word = wr_word;
      end
      if ($urandom_range(1) != 0) plan_frame({1'b1, dlpe_pkg::M_IDLE});
      if ($urandom_range(9) == 0) plan_q.push_back(rnd_beat(dlpe_pkg::KIND_WRITE));
      if ($urandom_range(4) != 0)
         plan_frame({1'b1, byte_w ? dlpe_pkg::M_W8_MSB : dlpe_pkg::M_W16_MSB});
      if ($urandom_range(4) != 0)
         plan_frame({1'b1, byte_w ? dlpe_pkg::M_W8_LSB : dlpe_pkg::M_W16_LSB});
      plan_frame({1'b1, byte_w ? dlpe_pkg::M_W8_DATA : dlpe_pkg::M_W16_DATA});
      plan_frame({1'b1, byte_w ? dlpe_pkg::M_W8_DATA : dlpe_pkg::M_W16_DATA});
      if (!byte_w) plan_frame({1'b1, dlpe_pkg::M_W16_DLSB});
      if ($urandom_range(9) == 0) word = 16'($urandom);
      if (byte_w) begin
         plan_frame({1'b1, dlpe_pkg::M_W8_ACK});
         plan_frame({1'b0, word[7:0]});
      end else begin
         plan_frame({1'b1, dlpe_pkg::M_W16_ACK});
         plan_frame({1'b0, word[15:8]});
         plan_frame({1'b0, word[7:0]});
      end
   endfunction

   function automatic void plan_noise();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: plan_q.push_back(rnd_beat(dlpe_pkg::KIND_FRAME));
            4: plan_q.push_back(rnd_beat(dlpe_pkg::KIND_RX_ERROR));
            5: plan_q.push_back(rnd_beat(dlpe_pkg::KIND_READ));
            6: plan_q.push_back(rnd_beat(dlpe_pkg::KIND_WRITE));
            7: begin
               case ($urandom_range(2))
                  0: plan_frame({1'b1, dlpe_pkg::M_RD_RES});
                  1: plan_frame({1'b1, dlpe_pkg::M_W16_ACK});
                  default: plan_frame({1'b1, dlpe_pkg::M_W8_ACK});
               endcase
               if ($urandom_range(1) != 0) plan_frame({1'b0, 8'($urandom)});
               plan_q.push_back(rnd_beat(dlpe_pkg::KIND_RX_ERROR));
            end
            8: plan_frame({1'b1, 8'(dlpe_pkg::MODE_FLOOR + 8'($urandom_range(47)))});
            default: plan_frame({1'b0, 8'($urandom)});
         endcase
      end
   endfunction

   task automatic send_beat(link_beat_type b, bit typed, dlpe_pkg::rsp_type want);
      dlpe_pkg::rsp_type calc;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid       <= 1'b1;
      req_kind        <= b.kind;
      req_frame       <= b.frame;
      req_address     <= b.address;
      req_byte_count  <= b.byte_count;
      req_write_width <= b.write_width;
      req_write_value <= b.write_value;
      do @(posedge clock); while (req_stall);
      calc = link_reply(b);
      reply_q.push_back(typed ? want : calc);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (reply_q.size() != 0);
   endtask

   always @(posedge clock) begin
      dlpe_pkg::rsp_type seen;
      dlpe_pkg::rsp_type want;
      seen = {rsp_tx_valid, rsp_tx_frame, rsp_read_valid, rsp_read_data, rsp_read_bytes,
              rsp_read_last, rsp_write_done, rsp_resync, rsp_stray, rsp_busy_res};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reply_q.size() == 0) begin
            bad_replies++;
            if (bad_replies <= 10)
               $display("unexpected reply beat: %h", seen);
         end else begin
            want = reply_q.pop_front();
            if (seen !== want) begin
               bad_replies++;
               if (bad_replies <= 10) begin
                  $display("want: tx %b %h rd %b %h %0d %b wd %b rs %b st %b bz %b",
                           want.tx_valid, want.tx_frame, want.read_valid, want.read_data,
                           want.read_bytes, want.read_last, want.write_done, want.resync,
                           want.stray, want.busy_res);
                  $display(" got: tx %b %h rd %b %h %0d %b wd %b rs %b st %b bz %b",
                           seen.tx_valid, seen.tx_frame, seen.read_valid, seen.read_data,
                           seen.read_bytes, seen.read_last, seen.write_done, seen.resync,
                           seen.stray, seen.busy_res);
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clock);
      $display("tb_diag_link_protocol_engine: FAIL");
      $finish;
   end

   initial begin
      link_beat_type b;
      int counted;
      int pick;

      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1CF, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h000, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, fixed_rsp(1'b0, 9'h000, 1'b0, 16'h0000, 2'd0, 1'b0, F_STRAY));
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1FF, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, fixed_rsp(1'b0, 9'h000, 1'b0, 16'h0000, 2'd0, 1'b0, F_RESYNC));
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1D0, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, fixed_rsp(1'b1, 9'h000, 1'b0, 16'h0000, 2'd0, 1'b0, 4'b0000));
      add_row(mk_beat(dlpe_pkg::KIND_RX_ERROR, 9'h000, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, fixed_rsp(1'b0, 9'h000, 1'b0, 16'h0000, 2'd0, 1'b0, F_RESYNC));
      add_row(mk_beat(dlpe_pkg::KIND_READ, 9'h000, 16'hFFFF, 8'd0, 2'd0, 16'h0000),
              1'b1, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_READ, 9'h1FF, 16'h0000, 8'd255, 2'd3, 16'hFFFF),
              1'b1, fixed_rsp(1'b0, 9'h000, 1'b0, 16'h0000, 2'd0, 1'b0, F_BUSY));
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1DA, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, fixed_rsp(1'b1, 9'h0FF, 1'b0, 16'h0000, 2'd0, 1'b0, 4'b0000));
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1D8, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h0AB, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h0CD, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, fixed_rsp(1'b1, 9'h1DA, 1'b1, 16'h0000, 2'd0, 1'b1, 4'b0000));
      add_row(mk_beat(dlpe_pkg::KIND_WRITE, 9'h000, 16'hFFFF, 8'd0, 2'd1, 16'hFFFF),
              1'b1, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_WRITE, 9'h000, 16'h0000, 8'd0, 2'd3, 16'h0000),
              1'b1, fixed_rsp(1'b0, 9'h000, 1'b0, 16'h0000, 2'd0, 1'b0, F_BUSY));
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1DC, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, fixed_rsp(1'b1, 9'h0FF, 1'b0, 16'h0000, 2'd0, 1'b0, 4'b0000));
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1D5, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, fixed_rsp(1'b1, 9'h0FF, 1'b0, 16'h0000, 2'd0, 1'b0, 4'b0000));
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1D6, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1D6, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1D7, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h0FF, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1D7, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h0FF, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b1, fixed_rsp(1'b0, 9'h000, 1'b0, 16'h0000, 2'd0, 1'b0, F_WDONE));
      add_row(mk_beat(dlpe_pkg::KIND_WRITE, 9'h000, 16'h8001, 8'd0, 2'd0, 16'hA55A),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1DE, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1DE, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1D4, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h1DF, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h0A5, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);
      add_row(mk_beat(dlpe_pkg::KIND_FRAME, 9'h05A, 16'h0000, 8'd0, 2'd0, 16'h0000),
              1'b0, NO_RSP);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
      drain_replies();

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 65 : (phase == 3) ? 38 : 0;
         stall_pct = (phase == 2) ? 65 : (phase == 3) ? 38 : 0;
         counted = 0;
         while (counted < BEATS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 35) plan_read();
            else if (pick < 75) plan_write();
            else plan_noise();
            while (plan_q.size() != 0) begin
               b = plan_q.pop_front();
               send_beat(b, 1'b0, NO_RSP);
               // ignored low mark frames do not count
               if (!(b.kind == dlpe_pkg::KIND_FRAME && b.frame[8] &&
                     b.frame[7:0] < dlpe_pkg::MODE_FLOOR))
                  counted++;
            end
         end
         // hold the sender until every reply is back
         drain_replies();
      end

      idle_pct = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      bad_replies += reply_q.size();
      if (bad_replies == 0) $display("tb_diag_link_protocol_engine: PASS");
      else $display("tb_diag_link_protocol_engine: FAIL");
      $finish;
   end

endmodule
